[sv/sldc_pkg.sv]
// Package for the skew line distance check: fixed widths, item types and
// saturation constants. No dependencies.
`default_nettype none
package sldc_pkg;

	// field widths
	localparam int POS_W   = 18;
	localparam int DIR_W   = 16;
	localparam int THR_W   = 17;
	localparam int THR_RST = 1280;

	// front datapath widths
	localparam int DIFF_W  = POS_W + 1;
	localparam int PROD_W  = 2 * DIR_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int COSS_W  = PROD_W + 2;
	localparam int TP_W    = DIFF_W + CROSS_W;
	localparam int TRIP_W  = TP_W + 2;
	localparam int MAG_W   = TRIP_W - 1;
	localparam int CMAG_W  = PROD_W;
	localparam int C2_W    = 2 * CMAG_W;
	localparam int ONE_SH  = 4 * (DIR_W - 2);

	// back datapath widths
	localparam int SIN_W   = ONE_SH + 1;
	localparam int ROOT_W  = ONE_SH / 2 + 1;
	localparam int REM_W   = SIN_W + 1;
	localparam int TRIAL_W = SIN_W + 3;
	localparam int Q_W     = POS_W;
	localparam int DREM_W  = ROOT_W + Q_W;

	localparam int SQ_STAGES  = ROOT_W;
	localparam int DIV_STAGES = Q_W;
	localparam int BK_STAGES  = SQ_STAGES + 1 + DIV_STAGES;

	localparam logic [POS_W-1:0] DIST_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0] DIST_MIN = {1'b1, {(POS_W-1){1'b0}}};

	// request from front to back
	typedef struct packed {
		logic [SIN_W-1:0] sin_sq;
		logic [MAG_W-1:0] mag;
		logic             tneg;
		logic             par;
	} front_t;

	// one back pipeline stage
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [MAG_W-1:0]  mag;
		logic [DREM_W-1:0] drem;
		logic [Q_W-1:0]    q;
		logic              tneg;
		logic              par;
		logic              sat;
	} back_t;

	// result request
	typedef struct packed {
		logic [POS_W-1:0] distance;
		logic             pt;
		logic             par;
	} result_t;

endpackage
`default_nettype wire

[sv/sldc_fifo.sv]
// Small register queue between pipeline parts.
// Depends on nothing; depth must be a power of two.
`default_nettype none
module sldc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      cnt_q;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = buf_q[rd_ptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (wr_en) buf_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

[sv/sldc_front.sv]
// Front part: tip difference, cross product, triple product, cosine and
// 1 - cos^2, in five stages. Depends on sldc_pkg.
`default_nettype none
module sldc_front import sldc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [POS_W-1:0] finger_tip [3],
	input  wire logic signed [DIR_W-1:0] finger_dir [3],
	input  wire logic signed [POS_W-1:0] tool_tip [3],
	input  wire logic signed [DIR_W-1:0] tool_dir [3],
	output logic                         out_valid,
	input  wire logic                    out_full,
	output front_t                       out_item
);
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [DIFF_W-1:0]  d_s1 [3];
	logic signed [PROD_W-1:0]  p_s1 [6];
	logic signed [PROD_W-1:0]  cd_s1 [3];
	logic signed [DIFF_W-1:0]  d_s2 [3];
	logic signed [CROSS_W-1:0] cr_s2 [3];
	logic signed [COSS_W-1:0]  cos_s2;
	logic signed [TP_W-1:0]    tp_s3 [3];
	logic        [CMAG_W-1:0]  cmag_s3;
	logic signed [TRIP_W-1:0]  t_s4;
	logic        [C2_W-1:0]    c2_s4;
	front_t                    item_s5;

	// stall the whole front when its last stage cannot drain
	assign adv       = !v_s5 || !out_full;
	assign in_ready  = adv;
	assign out_valid = v_s5;
	assign out_item  = item_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: tip difference and all direction products
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= DIFF_W'(tool_tip[i]) - DIFF_W'(finger_tip[i]);
				cd_s1[i] <= PROD_W'(finger_dir[i]) * PROD_W'(tool_dir[i]);
			end
			p_s1[0] <= PROD_W'(finger_dir[1]) * PROD_W'(tool_dir[2]);
			p_s1[1] <= PROD_W'(finger_dir[2]) * PROD_W'(tool_dir[1]);
			p_s1[2] <= PROD_W'(finger_dir[2]) * PROD_W'(tool_dir[0]);
			p_s1[3] <= PROD_W'(finger_dir[0]) * PROD_W'(tool_dir[2]);
			p_s1[4] <= PROD_W'(finger_dir[0]) * PROD_W'(tool_dir[1]);
			p_s1[5] <= PROD_W'(finger_dir[1]) * PROD_W'(tool_dir[0]);

			// stage 2: cross product and cosine
			for (int i = 0; i < 3; i++) begin
				d_s2[i]  <= d_s1[i];
				cr_s2[i] <= CROSS_W'(p_s1[2*i]) - CROSS_W'(p_s1[2*i+1]);
			end
			cos_s2 <= COSS_W'(cd_s1[0]) + COSS_W'(cd_s1[1]) + COSS_W'(cd_s1[2]);

			// stage 3: triple product terms and cosine magnitude
			for (int i = 0; i < 3; i++)
				tp_s3[i] <= TP_W'(d_s2[i]) * TP_W'(cr_s2[i]);
			cmag_s3 <= CMAG_W'(cos_s2[COSS_W-1] ? -cos_s2 : cos_s2);

			// stage 4: triple product and cos^2
			t_s4  <= TRIP_W'(tp_s3[0]) + TRIP_W'(tp_s3[1]) + TRIP_W'(tp_s3[2]);
			c2_s4 <= C2_W'(cmag_s3) * C2_W'(cmag_s3);

			// stage 5: classify parallel, form 1 - cos^2 and |T|
			item_s5.par    <= (c2_s4 >= (C2_W'(1) << ONE_SH));
			item_s5.sin_sq <= (c2_s4 >= (C2_W'(1) << ONE_SH)) ? '0 :
				(SIN_W'(1) << ONE_SH) - SIN_W'(c2_s4[ONE_SH-1:0]);
			item_s5.tneg   <= t_s4[TRIP_W-1];
			item_s5.mag    <= MAG_W'(t_s4[TRIP_W-1] ? -t_s4 : t_s4);
		end
	end

endmodule
`default_nettype wire

[sv/sldc_back.sv]
// Back part: bit-per-stage square root, bit-per-stage divide and final
// saturation and threshold test. Depends on sldc_pkg.
`default_nettype none
module sldc_back import sldc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire front_t           in_item,
	output logic                  in_pop,
	input  wire logic [THR_W-1:0] threshold,
	output logic                  out_valid,
	input  wire logic             out_full,
	output result_t               out_item
);
	logic  adv;
	logic  vld_s [BK_STAGES];
	back_t pipe_s [BK_STAGES];
	back_t head;
	back_t last;

	logic [POS_W-1:0]      dist_val;
	logic signed [POS_W:0] dist_x, thr_x;

	assign adv    = !vld_s[BK_STAGES-1] || !out_full;
	assign in_pop = adv && in_valid;

	always_comb begin
		head        = '0;
		head.rem    = REM_W'(in_item.sin_sq);
		head.mag    = in_item.mag;
		head.tneg   = in_item.tneg;
		head.par    = in_item.par;
	end

	for (genvar j = 0; j < BK_STAGES; j++) begin : g_st
		back_t cur, nxt;
		logic  vin;

		if (j == 0) begin : g_first
			assign cur = head;
			assign vin = in_valid;
		end else begin : g_rest
			assign cur = pipe_s[j-1];
			assign vin = vld_s[j-1];
		end

		if (j < SQ_STAGES) begin : g_sqrt
			// try the next root bit against the remainder
			localparam int K = SQ_STAGES - 1 - j;
			logic [TRIAL_W-1:0] trial;
			assign trial = (TRIAL_W'(cur.root) << (K + 1)) + (TRIAL_W'(1) << (2 * K));
			always_comb begin
				nxt = cur;
				if (TRIAL_W'(cur.rem) >= trial) begin
					nxt.rem  = cur.rem - REM_W'(trial);
					nxt.root = cur.root | (ROOT_W'(1) << K);
				end
			end
		end else if (j == SQ_STAGES) begin : g_pre
			// flag quotients that cannot fit, load the dividend
			logic ovf;
			assign ovf = cur.mag >= MAG_W'({cur.root, {Q_W{1'b0}}});
			always_comb begin
				nxt      = cur;
				nxt.sat  = ovf;
				nxt.q    = '0;
				nxt.drem = ovf ? '0 : DREM_W'(cur.mag);
			end
		end else begin : g_div
			// restoring divide step
			localparam int K = DIV_STAGES - 1 - (j - SQ_STAGES - 1);
			logic [DREM_W-1:0] dsh;
			assign dsh = DREM_W'(cur.root) << K;
			always_comb begin
				nxt = cur;
				if (cur.drem >= dsh) begin
					nxt.drem = cur.drem - dsh;
					nxt.q    = cur.q | (Q_W'(1) << K);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j] <= 1'b0;
			else if (adv) vld_s[j] <= vin;
		end

		always_ff @(posedge clk) begin
			if (adv) pipe_s[j] <= nxt;
		end
	end

	// saturate and sign the quotient
	assign last = pipe_s[BK_STAGES-1];
	always_comb begin
		if (last.par)
			dist_val = last.tneg ? DIST_MIN : DIST_MAX;
		else if (last.tneg)
			dist_val = (last.sat || last.q > DIST_MIN) ? DIST_MIN : -last.q;
		else
			dist_val = (last.sat || last.q[Q_W-1]) ? DIST_MAX : last.q;
	end

	assign dist_x = $signed({dist_val[POS_W-1], dist_val});
	assign thr_x  = $signed((POS_W+1)'(threshold));

	assign out_valid         = vld_s[BK_STAGES-1] && !out_full;
	assign out_item.distance = dist_val;
	assign out_item.par      = last.par;
	assign out_item.pt       = !last.par && (dist_x < thr_x) && (dist_x > -thr_x);

endmodule
`default_nettype wire

[sv/skew_line_distance_check.sv]
// Top level of the skew line distance check; instantiates sldc_front,
// sldc_back and two sldc_fifo queues. Depends on sldc_pkg.
//
// Signed shortest distance between two lines per request, with pointing and
// parallel flags. Throughput is one request per clock while no stage is
// stalled: the front (5 stages of multiplies and sums), a bit-per-stage
// square root (29 stages) and a bit-per-stage restoring divider (1 + 18
// stages) are fully pipelined. A 2-entry queue between front and back and
// a 2-entry result queue let each side stall alone; full rises only when
// the front pipeline is stalled on a full queue.
// The threshold register is sampled as a result leaves the back; write it only
// while no request is in flight.
`default_nettype none
module skew_line_distance_check import sldc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic signed [POS_W-1:0] finger_tip_x,
	input  wire logic signed [POS_W-1:0] finger_tip_y,
	input  wire logic signed [POS_W-1:0] finger_tip_z,
	input  wire logic signed [DIR_W-1:0] finger_dir_x,
	input  wire logic signed [DIR_W-1:0] finger_dir_y,
	input  wire logic signed [DIR_W-1:0] finger_dir_z,
	input  wire logic signed [POS_W-1:0] tool_tip_x,
	input  wire logic signed [POS_W-1:0] tool_tip_y,
	input  wire logic signed [POS_W-1:0] tool_tip_z,
	input  wire logic signed [DIR_W-1:0] tool_dir_x,
	input  wire logic signed [DIR_W-1:0] tool_dir_y,
	input  wire logic signed [DIR_W-1:0] tool_dir_z,
	input  wire logic                    cfg_we,
	input  wire logic        [THR_W-1:0] cfg_wdata,
	output logic                         empty,
	input  wire logic                    pop,
	output logic signed      [POS_W-1:0] signed_distance,
	output logic                         pointing_at,
	output logic                         parallel_lines
);
	logic [THR_W-1:0] threshold_q;

	logic    in_ready;
	logic    f_valid, mid_full, mid_empty, mid_pop;
	front_t  f_item, mid_item;
	logic    b_valid, res_full;
	result_t b_item, res_item;

	// hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) threshold_q <= THR_W'(THR_RST);
		else if (cfg_we) threshold_q <= cfg_wdata;
	end

	assign full = !in_ready;

	sldc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (push),
		.in_ready   (in_ready),
		.finger_tip ('{finger_tip_x, finger_tip_y, finger_tip_z}),
		.finger_dir ('{finger_dir_x, finger_dir_y, finger_dir_z}),
		.tool_tip   ('{tool_tip_x, tool_tip_y, tool_tip_z}),
		.tool_dir   ('{tool_dir_x, tool_dir_y, tool_dir_z}),
		.out_valid  (f_valid),
		.out_full   (mid_full),
		.out_item   (f_item)
	);

	sldc_fifo #(.WIDTH($bits(front_t)), .DEPTH(2)) u_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid && !mid_full),
		.wr_data (f_item),
		.rd_en   (mid_pop),
		.rd_data (mid_item),
		.full    (mid_full),
		.empty   (mid_empty)
	);

	sldc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!mid_empty),
		.in_item   (mid_item),
		.in_pop    (mid_pop),
		.threshold (threshold_q),
		.out_valid (b_valid),
		.out_full  (res_full),
		.out_item  (b_item)
	);

	sldc_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (b_valid),
		.wr_data (b_item),
		.rd_en   (pop && !empty),
		.rd_data (res_item),
		.full    (res_full),
		.empty   (empty)
	);

	assign signed_distance = res_item.distance;
	assign pointing_at     = res_item.pt;
	assign parallel_lines  = res_item.par;

endmodule
`default_nettype wire

[sv/sldc_checker.sv]
// Port-level checks for skew_line_distance_check, bound to the top level.
// Depends on sldc_pkg.
`default_nettype none
module sldc_checker import sldc_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    push,
	input wire logic                    full,
	input wire logic                    pop,
	input wire logic                    empty,
	input wire logic signed [POS_W-1:0] signed_distance,
	input wire logic                    pointing_at,
	input wire logic                    parallel_lines
);
	logic [7:0] open_q;

	// count requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) open_q <= '0;
		else open_q <= open_q + 8'(push && !full) - 8'(pop && !empty);
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> open_q != 8'd0)
		else $error("result shown with no request in flight");

	a_par_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && parallel_lines |-> !pointing_at)
		else $error("parallel result flagged as pointing");

	a_par_sat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && parallel_lines |->
			(signed_distance == DIST_MAX || signed_distance == DIST_MIN))
		else $error("parallel result not saturated");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(signed_distance))
		else $error("waiting result changed");

endmodule

bind skew_line_distance_check sldc_checker u_chk (.*);
`default_nettype wire
